// ===== hdl/midi_tep_pkg.sv =====
// Shared types, codes and constants of the per-track sequence event parser.
// No dependencies.
package midi_tep_pkg;

	localparam int TRACK_COUNT_DEF    = 16;
	localparam int MAX_DATA_BYTES_DEF = 4;
	localparam int OUT_DEPTH          = 4;
	localparam int OUT_PTR_W          = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W          = OUT_PTR_W + 1;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic KIND_EVENT   = 1'b0;
	localparam logic KIND_REFUSED = 1'b1;

	localparam logic [2:0] PH_DELTA = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_MTYPE = 3'd2;
	localparam logic [2:0] PH_MLEN  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;

	localparam logic [7:0] META_MARK   = 8'hFF;
	localparam logic [7:0] META_HALT_A = 8'h44;
	localparam logic [7:0] META_HALT_B = 8'h2E;

	typedef struct packed {
		logic       op;
		logic [3:0] track;
		logic [7:0] seq_byte;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  out_track;
		logic [31:0] delta_time;
		logic [7:0]  status;
		logic        is_meta;
		logic [7:0]  data_count;
		logic [7:0]  data0;
		logic [7:0]  data1;
		logic [7:0]  data2;
		logic [7:0]  data3;
		logic        truncated;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] delta_accum;
		logic [7:0]  event_status;
		logic [7:0]  running_status;
		logic [7:0]  bytes_left;
		logic [7:0]  data_index;
		logic [1:0]  halt_flags;
		logic        meta_flag;
	} state_hdr_t;

	typedef struct packed {
		logic wr_en;
		logic res_valid;
	} core_ctl_t;

	function automatic logic [7:0] chan_len(input logic [2:0] sel);
		logic [7:0] len;
		case (sel)
			3'd4, 3'd5: len = 8'd1;
			default:    len = 8'd2;
		endcase
		return len;
	endfunction

endpackage

// ===== hdl/midi_tep_if.sv =====
// Valid/ready channel interfaces for sequence bytes and parsed events.
// Depends on midi_tep_pkg.
interface midi_tep_seq_if;
	import midi_tep_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface midi_tep_evt_if;
	import midi_tep_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/midi_tep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module midi_tep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/midi_tep_core.sv =====
// Next-state and result logic for one byte applied to one track's parse state.
// Depends on midi_tep_pkg.
module midi_tep_core import midi_tep_pkg::*; #(
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
	input  state_hdr_t                      cur_hdr,
	input  logic [8*MAX_DATA_BYTES-1:0]     cur_store,
	input  logic [3:0]                      track,
	input  logic [7:0]                      seq_byte,
	output state_hdr_t                      nxt_hdr,
	output logic [8*MAX_DATA_BYTES-1:0]     nxt_store,
	output out_item_t                       result,
	output core_ctl_t                       ctl
);

	localparam int PADN = (MAX_DATA_BYTES > 4) ? MAX_DATA_BYTES : 4;

	state_hdr_t                  h;
	logic [8*MAX_DATA_BYTES-1:0] s;
	logic [8*PADN-1:0]           pad;
	logic                        emit;
	logic                        refuse;

	always_comb begin
		h      = cur_hdr;
		s      = cur_store;
		emit   = 1'b0;
		refuse = 1'b0;
		if (cur_hdr.halt_flags != 2'b00) begin
			refuse = 1'b1;
		end else begin
			case (cur_hdr.phase)
				PH_START: begin
					if (seq_byte == META_MARK) begin
						h.meta_flag = 1'b1;
						h.phase     = PH_MTYPE;
					end else if (seq_byte[7]) begin
						h.event_status   = seq_byte;
						h.running_status = seq_byte;
						h.bytes_left     = chan_len(seq_byte[6:4]);
						h.phase          = PH_DATA;
					end else begin
						h.event_status = cur_hdr.running_status;
						h.bytes_left   = chan_len(cur_hdr.running_status[6:4]) - 8'd1;
						for (int j = 0; j < MAX_DATA_BYTES; j++) begin
							if (cur_hdr.data_index == 8'(j)) begin
								s[j*8 +: 8] = seq_byte;
							end
						end
						if (cur_hdr.data_index != 8'hFF) begin
							h.data_index = cur_hdr.data_index + 8'd1;
						end
						if (h.bytes_left == 8'd0) begin
							emit = 1'b1;
						end else begin
							h.phase = PH_DATA;
						end
					end
				end
				PH_MTYPE: begin
					h.event_status = seq_byte;
					h.phase        = PH_MLEN;
				end
				PH_MLEN: begin
					h.bytes_left = seq_byte;
					if (seq_byte == 8'd0) begin
						emit = 1'b1;
					end else begin
						h.phase = PH_DATA;
					end
				end
				PH_DATA: begin
					for (int j = 0; j < MAX_DATA_BYTES; j++) begin
						if (cur_hdr.data_index == 8'(j)) begin
							s[j*8 +: 8] = seq_byte;
						end
					end
					if (cur_hdr.data_index != 8'hFF) begin
						h.data_index = cur_hdr.data_index + 8'd1;
					end
					if (cur_hdr.bytes_left != 8'd0) begin
						h.bytes_left = cur_hdr.bytes_left - 8'd1;
					end
					if (h.bytes_left == 8'd0) begin
						emit = 1'b1;
					end
				end
				default: begin
					h.delta_accum = {cur_hdr.delta_accum[24:0], seq_byte[6:0]};
					h.phase       = seq_byte[7] ? PH_DELTA : PH_START;
				end
			endcase
		end
	end

	assign pad = (8*PADN)'(s);

	always_comb begin
		result = '0;
		if (refuse) begin
			result.kind      = KIND_REFUSED;
			result.out_track = track;
		end else begin
			result.kind       = KIND_EVENT;
			result.out_track  = track;
			result.delta_time = h.delta_accum;
			result.status     = h.event_status;
			result.is_meta    = h.meta_flag;
			result.data_count = h.data_index;
			result.data0      = pad[7:0];
			result.data1      = pad[15:8];
			result.data2      = pad[23:16];
			result.data3      = pad[31:24];
			result.truncated  = (h.data_index > 8'(MAX_DATA_BYTES));
		end
	end

	always_comb begin
		nxt_hdr   = h;
		nxt_store = s;
		if (emit) begin
			if (h.meta_flag && (h.event_status == META_HALT_A)) begin
				nxt_hdr.halt_flags = h.halt_flags | 2'b01;
			end else if (h.meta_flag && (h.event_status == META_HALT_B)) begin
				nxt_hdr.halt_flags = h.halt_flags | 2'b10;
			end
			nxt_hdr.phase        = PH_DELTA;
			nxt_hdr.delta_accum  = '0;
			nxt_hdr.event_status = '0;
			nxt_hdr.bytes_left   = '0;
			nxt_hdr.data_index   = '0;
			nxt_hdr.meta_flag    = 1'b0;
			nxt_store            = '0;
		end
	end

	assign ctl.wr_en     = !refuse;
	assign ctl.res_valid = emit | refuse;

endmodule

// ===== hdl/midi_tep_out_fifo.sv =====
// Result queue between the parse stage and the event channel.
// Depends on midi_tep_pkg and midi_tep_if.
module midi_tep_out_fifo import midi_tep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  out_item_t            push_data,
	output logic [OUT_CNT_W-1:0] level,
	midi_tep_evt_if.source       evt
);

	out_item_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   count_q;
	logic                   pop;

	assign evt.valid   = (count_q != '0);
	assign evt.payload = mem_q[rd_ptr_q];
	assign pop         = evt.valid && evt.ready;
	assign level       = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/midi_track_event_parser.sv =====
// Per-track sequence event parser: top level with state RAM, forwarding and valid bits.
// Depends on midi_tep_pkg, midi_tep_if, midi_tep_ram, midi_tep_core, midi_tep_out_fifo.
// A byte is registered in the parse stage; its event then goes to the output queue.
// Throughput: one byte per cycle while the queue has room; state RAM read-modify-write,
// with the last write forwarded so back-to-back bytes of one track see fresh state.
// Reset: per-track valid bits clear at once, every track reads as zero state; no sweep.
module midi_track_event_parser import midi_tep_pkg::*; #(
	parameter int TRACK_COUNT    = TRACK_COUNT_DEF,
	parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	midi_tep_seq_if.sink   seq,
	midi_tep_evt_if.source evt
);

	localparam int AW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
	localparam int SW = 8 * MAX_DATA_BYTES;
	localparam int EW = $bits(state_hdr_t) + SW;

	logic                    valid_s1;
	in_item_t                item_s1;
	logic [TRACK_COUNT-1:0]  live_q;
	logic                    fwd_en_q;
	logic [AW-1:0]           fwd_addr_q;
	logic [EW-1:0]           fwd_data_q;

	logic [AW-1:0]           addr_s1;
	logic                    track_ok;
	logic [EW-1:0]           rdata;
	logic [EW-1:0]           cur_entry;
	logic [EW-1:0]           nxt_entry;
	state_hdr_t              cur_hdr;
	state_hdr_t              nxt_hdr;
	logic [SW-1:0]           cur_store;
	logic [SW-1:0]           nxt_store;
	out_item_t               result;
	core_ctl_t               ctl;
	logic                    do_byte;
	logic                    do_clear;
	logic                    wr_en;
	logic                    push;
	logic [OUT_CNT_W-1:0]    level;
	logic                    accept;

	assign accept    = seq.valid && seq.ready;
	assign seq.ready = ({1'b0, level} + {{OUT_CNT_W{1'b0}}, valid_s1})
		< (OUT_CNT_W+1)'(OUT_DEPTH);

	assign addr_s1  = AW'(item_s1.track);
	assign track_ok = ({3'b000, item_s1.track} < 7'(TRACK_COUNT));
	assign do_byte  = valid_s1 && track_ok && (item_s1.op == OP_BYTE);
	assign do_clear = valid_s1 && track_ok && (item_s1.op == OP_CLEAR);

	always_comb begin
		cur_entry = '0;
		if (track_ok && live_q[addr_s1]) begin
			cur_entry = (fwd_en_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata;
		end
	end

	assign cur_hdr   = state_hdr_t'(cur_entry[EW-1 -: $bits(state_hdr_t)]);
	assign cur_store = cur_entry[SW-1:0];
	assign nxt_entry = {nxt_hdr, nxt_store};
	assign wr_en     = do_byte && ctl.wr_en;
	assign push      = do_byte && ctl.res_valid;

	midi_tep_ram #(
		.WIDTH(EW),
		.DEPTH(TRACK_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (nxt_entry),
		.raddr (AW'(seq.payload.track)),
		.rdata (rdata)
	);

	midi_tep_core #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_core (
		.cur_hdr   (cur_hdr),
		.cur_store (cur_store),
		.track     (item_s1.track),
		.seq_byte  (item_s1.seq_byte),
		.nxt_hdr   (nxt_hdr),
		.nxt_store (nxt_store),
		.result    (result),
		.ctl       (ctl)
	);

	midi_tep_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.level     (level),
		.evt       (evt)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= seq.payload;
		end
		fwd_addr_q <= addr_s1;
		fwd_data_q <= nxt_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_en_q <= 1'b0;
			live_q   <= '0;
		end else begin
			valid_s1 <= accept;
			fwd_en_q <= wr_en;
			if (wr_en) begin
				live_q[addr_s1] <= 1'b1;
			end else if (do_clear) begin
				live_q[addr_s1] <= 1'b0;
			end
		end
	end

endmodule

// ===== verif/midi_tep_checker.sv =====
// Scoreboard for the per-track sequence event parser: tracks every track's parse state,
// predicts the events of each byte transfer and compares them with the output channel.
// Depends on midi_tep_pkg and midi_tep_if.
module midi_tep_checker import midi_tep_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	midi_tep_seq_if seq,
	midi_tep_evt_if evt,
	output int      mismatches,
	output int      waiting
);

	localparam int NTRK  = TRACK_COUNT_DEF;
	localparam int NKEEP = MAX_DATA_BYTES_DEF;
	localparam logic [7:0] DATA_LEN [8] = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'd2};

	logic [2:0]  phase      [NTRK];
	logic [31:0] delta      [NTRK];
	logic [7:0]  ev_status  [NTRK];
	logic [7:0]  run_status [NTRK];
	logic [7:0]  remaining  [NTRK];
	logic [7:0]  count      [NTRK];
	logic [7:0]  kept       [NTRK][NKEEP];
	logic [1:0]  halt       [NTRK];
	logic        meta       [NTRK];

	out_item_t events_due [$];
	int        errs      = 0;
	int        due_count = 0;

	assign mismatches = errs;
	assign waiting    = due_count;

	function automatic void clear_track(int t);
		phase[t]     = PH_DELTA;
		delta[t]     = '0;
		ev_status[t] = '0;
		remaining[t] = '0;
		count[t]     = '0;
		meta[t]      = 1'b0;
		for (int j = 0; j < NKEEP; j++)
			kept[t][j] = '0;
	endfunction

	function automatic void keep_byte(int t, logic [7:0] b);
		if (count[t] < 8'(NKEEP))
			kept[t][count[t]] = b;
		if (count[t] != 8'hFF)
			count[t]++;
	endfunction

	function automatic out_item_t close_event(int t);
		out_item_t ev;
		ev            = '0;
		ev.kind       = KIND_EVENT;
		ev.out_track  = 4'(t);
		ev.delta_time = delta[t];
		ev.status     = ev_status[t];
		ev.is_meta    = meta[t];
		ev.data_count = count[t];
		ev.data0      = kept[t][0];
		ev.data1      = kept[t][1];
		ev.data2      = kept[t][2];
		ev.data3      = kept[t][3];
		ev.truncated  = count[t] > 8'(NKEEP);
		if (meta[t]) begin
			if (ev_status[t] == META_HALT_A)
				halt[t][0] = 1'b1;
			else if (ev_status[t] == META_HALT_B)
				halt[t][1] = 1'b1;
		end
		clear_track(t);
		return ev;
	endfunction

	function automatic bit parse_item(in_item_t it, output out_item_t ev);
		int         t;
		logic [7:0] b;
		t  = it.track;
		b  = it.seq_byte;
		ev = '0;
		if (it.op == OP_CLEAR) begin
			clear_track(t);
			run_status[t] = '0;
			halt[t]       = '0;
			return 1'b0;
		end
		if (halt[t] != 2'b00) begin
			ev.kind      = KIND_REFUSED;
			ev.out_track = it.track;
			return 1'b1;
		end
		case (phase[t])
			PH_START: begin
				if (b == META_MARK) begin
					meta[t]  = 1'b1;
					phase[t] = PH_MTYPE;
				end else if (b[7]) begin
					ev_status[t]  = b;
					run_status[t] = b;
					remaining[t]  = DATA_LEN[b[6:4]];
					phase[t]      = PH_DATA;
				end else begin
					ev_status[t] = run_status[t];
					remaining[t] = DATA_LEN[run_status[t][6:4]] - 8'd1;
					keep_byte(t, b);
					if (remaining[t] == 8'd0) begin
						ev = close_event(t);
						return 1'b1;
					end
					phase[t] = PH_DATA;
				end
			end
			PH_MTYPE: begin
				ev_status[t] = b;
				phase[t]     = PH_MLEN;
			end
			PH_MLEN: begin
				remaining[t] = b;
				if (b == 8'd0) begin
					ev = close_event(t);
					return 1'b1;
				end
				phase[t] = PH_DATA;
			end
			PH_DATA: begin
				keep_byte(t, b);
				if (remaining[t] != 8'd0)
					remaining[t]--;
				if (remaining[t] == 8'd0) begin
					ev = close_event(t);
					return 1'b1;
				end
			end
			default: begin
				delta[t] = {delta[t][24:0], b[6:0]};
				phase[t] = b[7] ? PH_DELTA : PH_START;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic string show(out_item_t e);
		return $sformatf("kind=%0d trk=%0d dt=%h st=%h meta=%0d n=%0d d=%h %h %h %h trunc=%0d",
			e.kind, e.out_track, e.delta_time, e.status, e.is_meta, e.data_count,
			e.data0, e.data1, e.data2, e.data3, e.truncated);
	endfunction

	function automatic string diff_fields(out_item_t e, out_item_t g);
		string s;
		s = "";
		if (e.kind !== g.kind)             s = {s, " kind"};
		if (e.out_track !== g.out_track)   s = {s, " out_track"};
		if (e.delta_time !== g.delta_time) s = {s, " delta_time"};
		if (e.status !== g.status)         s = {s, " status"};
		if (e.is_meta !== g.is_meta)       s = {s, " is_meta"};
		if (e.data_count !== g.data_count) s = {s, " data_count"};
		if (e.data0 !== g.data0)           s = {s, " data0"};
		if (e.data1 !== g.data1)           s = {s, " data1"};
		if (e.data2 !== g.data2)           s = {s, " data2"};
		if (e.data3 !== g.data3)           s = {s, " data3"};
		if (e.truncated !== g.truncated)   s = {s, " truncated"};
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t ev;
		out_item_t due;
		string     wrong;
		if (!arst_n) begin
			for (int t = 0; t < NTRK; t++) begin
				clear_track(t);
				run_status[t] = '0;
				halt[t]       = '0;
			end
			events_due.delete();
			due_count = 0;
		end else begin
			if (seq.valid && seq.ready) begin
				if (parse_item(seq.payload, ev))
					events_due.push_back(ev);
			end
			if (evt.valid && evt.ready) begin
				if (events_due.size() == 0) begin
					if (errs < 10)
						$display("unexpected event: %s", show(evt.payload));
					errs++;
				end else begin
					due   = events_due.pop_front();
					wrong = diff_fields(due, evt.payload);
					if (wrong != "") begin
						if (errs < 10)
							$display("event mismatch in%s\n  expected %s\n  actual   %s",
								wrong, show(due), show(evt.payload));
						errs++;
					end
				end
			end
			due_count = events_due.size();
		end
	end

endmodule

// ===== verif/tb_midi_track_event_parser.sv =====
// Testbench top for midi_track_event_parser: drives interleaved per-track sequence bytes,
// directed cases first, then random events, and reports the verdict of midi_tep_checker.
// Depends on midi_tep_pkg, midi_tep_if, midi_tep_checker and the parser RTL.
module tb_midi_track_event_parser import midi_tep_pkg::*; ;

	localparam int NTRK       = TRACK_COUNT_DEF;
	localparam int ITEMS      = 1600;
	localparam int QUIET_MAX  = 2000;

	localparam in_item_t OPENING [27] = '{
		{OP_BYTE, 4'd1, 8'h00}, {OP_BYTE, 4'd1, 8'h12}, {OP_BYTE, 4'd1, 8'h34},
		{OP_BYTE, 4'd0, 8'h81}, {OP_BYTE, 4'd0, 8'hFF}, {OP_BYTE, 4'd0, 8'h7F},
		{OP_BYTE, 4'd0, 8'h90}, {OP_BYTE, 4'd0, 8'h3C}, {OP_BYTE, 4'd0, 8'h7F},
		{OP_BYTE, 4'd15, 8'h00}, {OP_BYTE, 4'd15, 8'hC5}, {OP_BYTE, 4'd15, 8'h05},
		{OP_BYTE, 4'd15, 8'h00}, {OP_BYTE, 4'd15, 8'hFF}, {OP_BYTE, 4'd15, 8'h2E},
		{OP_BYTE, 4'd15, 8'h00}, {OP_BYTE, 4'd15, 8'h80}, {OP_CLEAR, 4'd15, 8'h00},
		{OP_BYTE, 4'd2, 8'h00}, {OP_BYTE, 4'd2, 8'hFF}, {OP_BYTE, 4'd2, 8'h01},
		{OP_BYTE, 4'd2, 8'h05}, {OP_BYTE, 4'd2, 8'h11}, {OP_BYTE, 4'd2, 8'h22},
		{OP_BYTE, 4'd2, 8'h33}, {OP_BYTE, 4'd2, 8'h44}, {OP_BYTE, 4'd2, 8'hFF}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	int   sent   = 0;
	int   mismatches;
	int   waiting;

	in_item_t   track_q [NTRK][$];
	logic [7:0] gen_run [NTRK];

	midi_tep_seq_if seq_ch ();
	midi_tep_evt_if evt_ch ();

	midi_track_event_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seq    (seq_ch),
		.evt    (evt_ch)
	);

	midi_tep_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq        (seq_ch),
		.evt        (evt_ch),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			evt_ch.ready <= 1'b0;
		else
			evt_ch.ready <= steady || ($urandom_range(99) >= 10);
	end

	function automatic in_item_t byte_item(logic [3:0] t, logic [7:0] b);
		return '{op: OP_BYTE, track: t, seq_byte: b};
	endfunction

	function automatic in_item_t clear_item(logic [3:0] t);
		return '{op: OP_CLEAR, track: t, seq_byte: 8'h00};
	endfunction

	task automatic send(in_item_t it);
		seq_ch.valid   <= 1'b1;
		seq_ch.payload <= it;
		do
			@(posedge clk);
		while (!seq_ch.ready);
		sent++;
		steady = (sent >= 600) && (sent < 900);
		if (!steady && $urandom_range(99) < 10) begin
			seq_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic queue_event(logic [3:0] t);
		int         pick;
		int         len;
		int         n;
		bit         halting;
		logic [7:0] st;
		if ($urandom_range(99) < 3) begin
			track_q[t].push_back(clear_item(t));
			gen_run[t] = 8'h00;
		end
		if ($urandom_range(99) < 4) begin
			track_q[t].push_back(byte_item(t, 8'($urandom_range(255))));
			return;
		end
		n = ($urandom_range(99) < 80) ? 1 : $urandom_range(2, 5);
		for (int i = 1; i < n; i++)
			track_q[t].push_back(byte_item(t, 8'h80 | 8'($urandom_range(127))));
		track_q[t].push_back(byte_item(t, 8'($urandom_range(127))));
		pick = $urandom_range(99);
		if (pick < 20) begin
			halting = $urandom_range(99) < 15;
			if (halting)
				st = $urandom_range(1) ? META_HALT_A : META_HALT_B;
			else
				st = 8'($urandom_range(255));
			pick = $urandom_range(99);
			if (pick < 10)
				len = 0;
			else if (pick < 85)
				len = $urandom_range(1, 6);
			else if (pick < 98)
				len = $urandom_range(7, 24);
			else
				len = $urandom_range(200, 255);
			track_q[t].push_back(byte_item(t, META_MARK));
			track_q[t].push_back(byte_item(t, st));
			track_q[t].push_back(byte_item(t, 8'(len)));
			for (int i = 0; i < len; i++)
				track_q[t].push_back(byte_item(t, 8'($urandom_range(255))));
			if (halting) begin
				repeat ($urandom_range(1, 3))
					track_q[t].push_back(byte_item(t, 8'($urandom_range(255))));
				track_q[t].push_back(clear_item(t));
				gen_run[t] = 8'h00;
			end
		end else if (pick < 70) begin
			st         = 8'($urandom_range(128, 254));
			gen_run[t] = st;
			n          = (st[6:5] == 2'b10) ? 1 : 2;
			track_q[t].push_back(byte_item(t, st));
			for (int i = 0; i < n; i++)
				track_q[t].push_back(byte_item(t, 8'($urandom_range(255))));
		end else begin
			n = (gen_run[t][6:5] == 2'b10) ? 1 : 2;
			track_q[t].push_back(byte_item(t, 8'($urandom_range(127))));
			for (int i = 1; i < n; i++)
				track_q[t].push_back(byte_item(t, 8'($urandom_range(255))));
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_MAX) begin
			@(posedge clk);
			if ((seq_ch.valid && seq_ch.ready) || (evt_ch.valid && evt_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL midi_track_event_parser");
		$finish;
	end

	initial begin : stimulus
		logic [3:0] t;
		seq_ch.valid   <= 1'b0;
		seq_ch.payload <= '0;
		for (int i = 0; i < NTRK; i++)
			gen_run[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (OPENING[i])
			send(OPENING[i]);
		gen_run[0] = 8'h90;
		while (sent < ITEMS) begin
			t = 4'($urandom_range(NTRK - 1));
			if (track_q[t].size() == 0)
				queue_event(t);
			send(track_q[t].pop_front());
		end
		seq_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("PASS midi_track_event_parser");
		else
			$display("FAIL midi_track_event_parser");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/midi_tep_pkg.sv
hdl/midi_tep_if.sv
hdl/midi_tep_ram.sv
hdl/midi_tep_core.sv
hdl/midi_tep_out_fifo.sv
hdl/midi_track_event_parser.sv
verif/midi_tep_checker.sv
verif/tb_midi_track_event_parser.sv
